// ===== design/five_point_laplacian_zero_border_unit_macros.svh =====
// Assertion macros for the Laplacian filter checker.
`ifndef FIVE_POINT_LAPLACIAN_ZERO_BORDER_UNIT_MACROS_SVH
`define FIVE_POINT_LAPLACIAN_ZERO_BORDER_UNIT_MACROS_SVH

// Property checked while out of reset.
`define LAPZB_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every edge, reset included.
`define LAPZB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/lapzb_pkg.sv =====
// Package for the five-point Laplacian filter: widths, codes and stage types.
`timescale 1ns / 1ps

package lapzb_pkg;

    // Field widths
    localparam int PIXEL_W    = 8;
    localparam int LAP_W      = 11;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_ADDR_W = 1;

    // Result range
    localparam int LAP_MIN = -1020;
    localparam int LAP_MAX = 1020;

    // Register defaults before clamping
    localparam int WIDTH_DEFAULT  = 640;
    localparam int HEIGHT_DEFAULT = 480;
    localparam int DIM_MIN        = 2;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Item kinds carried on tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Flags that ride with an item from accept into the compute stage
    typedef struct packed {
        logic par;   // row parity: bank holding the row two above
        logic emit;  // this item produces a result
    } item_flags_t;

endpackage

// ===== design/five_point_laplacian_zero_border_unit.sv =====
// A pixel's result is registered as the item W+1 positions later advances out of stage 1
// (W = clamped image_width); results leave in raster order. Throughput: one item per cycle
// unless output stalls, set by the two line-memory banks (one read, one write each).
// Reset (aresetn low, synchronous): clears position counters, window, pipeline and output
// valids; width/height return to 640/480. Line memories are not cleared and need no pass.
`timescale 1ns / 1ps

module five_point_laplacian_zero_border_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config write port
    input  logic                              cfg_we,
    input  logic [lapzb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [lapzb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lapzb_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] pixel
    input  logic [0:0]                        s_tuser,   // [0] opcode
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lapzb_pkg::M_TDATA_W-1:0]   m_tdata,   // [10:0] laplacian, [15:11] zero
    output logic                              m_tlast    // frame_last
);
    import lapzb_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;   // column / address
    localparam int WW = $clog2(MAX_WIDTH + 1);                      // clamped width
    localparam int HW = $clog2(MAX_HEIGHT + 1);                     // clamped height
    localparam int RW = $clog2(MAX_HEIGHT + 2);                     // row count, up to H+1
    localparam int W_RST = (WIDTH_DEFAULT > MAX_WIDTH) ? MAX_WIDTH : WIDTH_DEFAULT;
    localparam int H_RST = (HEIGHT_DEFAULT > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_DEFAULT;

    // ---------------- configuration ----------------
    logic [WW-1:0] w_reg, w_next;
    logic [HW-1:0] h_reg, h_next;

    // clamp on write so the datapath sees the legal dimension
    always_comb begin
        w_next = w_reg;
        h_next = h_reg;
        if (cfg_we && cfg_addr == REG_IMAGE_WIDTH) begin
            if (cfg_wdata < CFG_DATA_W'(DIM_MIN)) w_next = WW'(DIM_MIN);
            else if (32'(cfg_wdata) > 32'(MAX_WIDTH)) w_next = WW'(MAX_WIDTH);
            else w_next = WW'(cfg_wdata);
        end
        if (cfg_we && cfg_addr == REG_IMAGE_HEIGHT) begin
            if (cfg_wdata < CFG_DATA_W'(DIM_MIN)) h_next = HW'(DIM_MIN);
            else if (32'(cfg_wdata) > 32'(MAX_HEIGHT)) h_next = HW'(MAX_HEIGHT);
            else h_next = HW'(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg <= WW'(W_RST);
            h_reg <= HW'(H_RST);
        end else begin
            w_reg <= w_next;
            h_reg <= h_next;
        end
    end

    // ---------------- handshake ----------------
    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg, m_valid_next;
    logic s1_adv;
    logic accept;

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // ---------------- accept stage: stream position ----------------
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          in_frame, emit_a, last_a;
    logic [PIXEL_W-1:0] bot_a;

    always_comb begin
        in_frame = (32'(row_reg) < 32'(h_reg)) && (s_tuser[0] == OP_PIXEL);
        bot_a    = in_frame ? s_tdata[PIXEL_W-1:0] : '0;
        emit_a   = (row_reg > RW'(1)) || (row_reg == RW'(1) && col_reg != '0);
        // the final result is due at the first column of row H+1
        last_a   = (32'(row_reg) == 32'(h_reg) + 32'd1) && (col_reg == '0);
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (last_a) begin
                col_next = '0;
                row_next = '0;
            end else if (WW'(col_reg) + WW'(1) >= w_reg) begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage 1 item register ----------------
    item_flags_t        s1_flags_reg, s1_flags_next;
    logic [CW-1:0]      s1_col_reg, s1_col_next;
    logic [PIXEL_W-1:0] s1_bot_reg, s1_bot_next;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) s1_valid_next = 1'b1;
        else if (s1_adv) s1_valid_next = 1'b0;
        s1_flags_next = s1_flags_reg;
        s1_col_next   = s1_col_reg;
        s1_bot_next   = s1_bot_reg;
        if (accept) begin
            s1_flags_next.par  = row_reg[0];
            s1_flags_next.emit = emit_a;
            s1_col_next        = col_reg;
            s1_bot_next        = bot_a;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_flags_reg <= s1_flags_next;
        s1_col_reg   <= s1_col_next;
        s1_bot_reg   <= s1_bot_next;
    end

    // ---------------- line memories: one bank per row parity ----------------
    logic [PIXEL_W-1:0] bank0_mem [MAX_WIDTH];
    logic [PIXEL_W-1:0] bank1_mem [MAX_WIDTH];
    logic [PIXEL_W-1:0] rd0_reg, rd1_reg;
    logic               mem_we;

    always_ff @(posedge aclk) begin
        if (mem_we && !s1_flags_reg.par) bank0_mem[s1_col_reg] <= s1_bot_reg;
        if (accept) rd0_reg <= bank0_mem[col_reg];
    end

    always_ff @(posedge aclk) begin
        if (mem_we && s1_flags_reg.par) bank1_mem[s1_col_reg] <= s1_bot_reg;
        if (accept) rd1_reg <= bank1_mem[col_reg];
    end

    // ---------------- stage 1: stencil ----------------
    logic [PIXEL_W-1:0] up_reg, up_next;
    logic [PIXEL_W-1:0] ctr_reg, ctr_next;
    logic [PIXEL_W-1:0] dn_reg, dn_next;
    logic [PIXEL_W-1:0] lf_reg, lf_next;
    logic [CW-1:0]      ocol_reg, ocol_next;
    logic [HW-1:0]      orow_reg, orow_next;
    logic [PIXEL_W-1:0] top_b, mid_b;
    logic [PIXEL_W-1:0] up_v, dn_v, lf_v, rt_v;
    logic               col_end, row_end, last_b;
    logic [LAP_W-1:0]   sum_b;

    always_comb begin
        top_b   = s1_flags_reg.par ? rd1_reg : rd0_reg;
        mid_b   = s1_flags_reg.par ? rd0_reg : rd1_reg;
        col_end = (WW'(ocol_reg) + WW'(1) >= w_reg);
        row_end = (orow_reg + HW'(1) >= h_reg);
        last_b  = col_end && row_end;
        // neighbors outside the frame count as zero
        up_v  = (orow_reg != '0) ? up_reg : '0;
        dn_v  = row_end ? '0 : dn_reg;
        lf_v  = (ocol_reg != '0) ? lf_reg : '0;
        rt_v  = col_end ? '0 : mid_b;
        sum_b = LAP_W'(up_v) + LAP_W'(dn_v) + LAP_W'(lf_v) + LAP_W'(rt_v)
              - (LAP_W'(ctr_reg) << 2);
        mem_we = s1_adv && !(s1_flags_reg.emit && last_b);
    end

    // window shift and output position
    always_comb begin
        up_next   = up_reg;
        ctr_next  = ctr_reg;
        dn_next   = dn_reg;
        lf_next   = lf_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        if (cfg_we || (s1_adv && s1_flags_reg.emit && last_b)) begin
            up_next   = '0;
            ctr_next  = '0;
            dn_next   = '0;
            lf_next   = '0;
            ocol_next = '0;
            orow_next = '0;
        end else if (s1_adv) begin
            lf_next  = ctr_reg;
            up_next  = top_b;
            ctr_next = mid_b;
            dn_next  = s1_bot_reg;
            if (s1_flags_reg.emit) begin
                if (col_end) begin
                    ocol_next = '0;
                    orow_next = orow_reg + HW'(1);
                end else begin
                    ocol_next = ocol_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg   <= '0;
            ctr_reg  <= '0;
            dn_reg   <= '0;
            lf_reg   <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
        end else begin
            up_reg   <= up_next;
            ctr_reg  <= ctr_next;
            dn_reg   <= dn_next;
            lf_reg   <= lf_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
        end
    end

    // ---------------- output register ----------------
    logic [LAP_W-1:0] lap_reg, lap_next;
    logic             tlast_reg, tlast_next;

    always_comb begin
        m_valid_next = m_valid_reg;
        lap_next     = lap_reg;
        tlast_next   = tlast_reg;
        if (s1_adv && s1_flags_reg.emit) begin
            m_valid_next = 1'b1;
            lap_next     = sum_b;
            tlast_next   = last_b;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lap_reg   <= lap_next;
        tlast_reg <= tlast_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - LAP_W)'(0), lap_reg};
    assign m_tlast  = tlast_reg;

endmodule

// ===== design/lapzb_checker.sv =====
// Port-level checker for the Laplacian filter, bound to the top level.
`timescale 1ns / 1ps
`include "five_point_laplacian_zero_border_unit_macros.svh"

module lapzb_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [lapzb_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                             m_tlast
);
    import lapzb_pkg::*;

    // a stalled result beat stays up
    `LAPZB_ASSERT(a_m_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")

    // a stalled result beat keeps its payload
    `LAPZB_ASSERT(a_m_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    // result stays within the stencil range with zero padding
    `LAPZB_ASSERT(a_lap_range, aclk, aresetn, m_tvalid |-> ($signed(m_tdata[LAP_W-1:0]) >= LAP_MIN) && ($signed(m_tdata[LAP_W-1:0]) <= LAP_MAX) && (m_tdata[M_TDATA_W-1:LAP_W] == '0), "laplacian out of range")

    // reset empties the pipeline: no result, input side open
    `LAPZB_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid && s_tready, "pipeline not empty after reset")

endmodule

bind five_point_laplacian_zero_border_unit lapzb_checker u_lapzb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== bench/five_point_laplacian_zero_border_unit_test.sv =====
// Self-checking bench for the five-point Laplacian filter: stream stimulus, predictor, checker.
`timescale 1ns / 1ps

module five_point_laplacian_zero_border_unit_test;
    import lapzb_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int LINE_DEPTH    = 2 * MAX_W;
    localparam int CENTRE_WEIGHT = -4;
    localparam int HOLD_OFF      = 8;    // idle cycles before a register write
    localparam int TAIL_CYCLES   = 20;   // settle time at the end of the run
    localparam int RANDOM_ITEMS  = 550;

    // One expected result beat
    typedef struct packed {
        logic [LAP_W-1:0] lap;
        logic             frame_last;
    } lap_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [7:0] pixel
    logic [0:0]            s_tuser;   // [0] opcode
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [10:0] laplacian, [15:11] zero
    logic                  m_tlast;   // frame_last

    // Knobs for random idling on either side
    bit source_gaps_on;
    bit sink_stalls_on;

    int mismatch_count;
    int results_seen;

    // Expected results, oldest first
    lap_result_t pending_laplacians[$];

    // Predictor state
    logic [CFG_DATA_W-1:0] width_cfg;
    logic [CFG_DATA_W-1:0] height_cfg;
    logic [PIXEL_W-1:0]    line_mem [LINE_DEPTH];
    int                    in_col;
    int                    in_row;
    int                    out_col;
    int                    out_row;
    logic [PIXEL_W-1:0]    win_up;
    logic [PIXEL_W-1:0]    win_centre;
    logic [PIXEL_W-1:0]    win_down;
    logic [PIXEL_W-1:0]    win_left;

    five_point_laplacian_zero_border_unit #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Safety net against a hung run
    initial begin
        #20_000_000;
        $display("five_point_laplacian_zero_border_unit verification failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Out-of-range frame sizes saturate
    function automatic int bound_dim(input int v, input int hi);
        if (v < DIM_MIN) return DIM_MIN;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int frame_w();
        return bound_dim(int'(width_cfg), MAX_W);
    endfunction

    function automatic int frame_h();
        return bound_dim(int'(height_cfg), MAX_H);
    endfunction

    task automatic restart_stream();
        in_col     = 0;
        in_row     = 0;
        out_col    = 0;
        out_row    = 0;
        win_up     = '0;
        win_centre = '0;
        win_down   = '0;
        win_left   = '0;
    endtask

    task automatic reset_predictor();
        width_cfg  = CFG_DATA_W'(WIDTH_DEFAULT);
        height_cfg = CFG_DATA_W'(HEIGHT_DEFAULT);
        foreach (line_mem[i]) line_mem[i] = '0;
        restart_stream();
    endtask

    // Advance the model by one accepted stream beat
    task automatic predict_laplacian(input logic op, input logic [PIXEL_W-1:0] pix);
        int w, h, c, r, colx, top_slot, mid_slot;
        int up_v, down_v, left_v, right_v, sum;
        logic [PIXEL_W-1:0] bot, top_px, mid_px;
        logic last;
        lap_result_t res;
        w = frame_w();
        h = frame_h();
        c = in_col;
        r = in_row;
        // drain items and anything past the last row feed zeros
        bot = (r < h && op == OP_PIXEL) ? pix : '0;
        colx = (c < MAX_W) ? c : MAX_W - 1;
        top_slot = (r % 2) * MAX_W + colx;
        mid_slot = ((r + 1) % 2) * MAX_W + colx;
        top_px = line_mem[top_slot];
        mid_px = line_mem[mid_slot];

        if (r > 1 || (r == 1 && c >= 1)) begin
            up_v    = (out_row > 0)     ? int'(win_up)   : 0;
            down_v  = (out_row + 1 < h) ? int'(win_down) : 0;
            left_v  = (out_col > 0)     ? int'(win_left) : 0;
            right_v = (out_col + 1 < w) ? int'(mid_px)   : 0;
            sum = up_v + down_v + left_v + right_v + CENTRE_WEIGHT * int'(win_centre);
            last = (out_row + 1 >= h) && (out_col + 1 >= w);
            res.lap = sum[LAP_W-1:0];
            res.frame_last = last;
            pending_laplacians.push_back(res);
            if (last) begin
                restart_stream();
                return;
            end
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end

        // shift the window one column and store the new bottom pixel
        win_left   = win_centre;
        win_up     = top_px;
        win_centre = mid_px;
        win_down   = bot;
        line_mem[top_slot] = bot;

        in_col = c + 1;
        if (in_col >= w) begin
            in_col = 0;
            in_row = r + 1;
        end
    endtask

    // ---------------------------------------------------------------
    // Random helpers
    // ---------------------------------------------------------------

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic int source_gap();
        if (!source_gaps_on || $urandom_range(0, 99) < 70) return 0;
        return idle_len();
    endfunction

    // Bias toward the intensity extremes
    function automatic logic [PIXEL_W-1:0] random_pixel();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20) return '0;
        if (roll < 40) return '1;
        return PIXEL_W'($urandom_range(0, 255));
    endfunction

    // ---------------------------------------------------------------
    // Stream and register drivers
    // ---------------------------------------------------------------

    // Send one beat; returns at the accepting edge
    task automatic push_pixel_beat(input logic op, input logic [PIXEL_W-1:0] pix);
        int gap;
        gap = source_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= op;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        predict_laplacian(op, pix);
    endtask

    // Stop sending and wait until every expected result has arrived
    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_laplacians.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr, input int value);
        wait_for_results();
        repeat (HOLD_OFF) @(posedge aclk);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge aclk);
        if (addr == REG_IMAGE_WIDTH) width_cfg = CFG_DATA_W'(value);
        else height_cfg = CFG_DATA_W'(value);
        restart_stream();
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input int w, input int h);
        write_register(REG_IMAGE_WIDTH, w);
        write_register(REG_IMAGE_HEIGHT, h);
    endtask

    // One well-formed frame of random pixels, then the flush beats
    task automatic send_frame();
        int w, h;
        w = frame_w();
        h = frame_h();
        for (int i = 0; i < w * h; i++) push_pixel_beat(OP_PIXEL, random_pixel());
        for (int i = 0; i <= w; i++) push_pixel_beat(OP_DRAIN, PIXEL_W'($urandom_range(0, 255)));
    endtask

    // ---------------------------------------------------------------
    // Result side: random backpressure and checking
    // ---------------------------------------------------------------

    initial begin : sink_ready
        int hold;
        hold = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) hold--;
            else if (sink_stalls_on && $urandom_range(0, 99) < 15) hold = idle_len();
            m_tready <= (hold == 0);
        end
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("MISMATCH %s at result %0d: expected %0d, got %0d",
                 what, results_seen, want, got);
        mismatch_count++;
    endtask

    task automatic check_result_beat();
        lap_result_t want;
        if (pending_laplacians.size() == 0) begin
            report_mismatch("unexpected result beat", 0, int'($signed(m_tdata[LAP_W-1:0])));
        end else begin
            want = pending_laplacians.pop_front();
            if (m_tdata[LAP_W-1:0] !== want.lap)
                report_mismatch("laplacian", int'($signed(want.lap)),
                                int'($signed(m_tdata[LAP_W-1:0])));
            if (m_tdata[M_TDATA_W-1:LAP_W] !== '0)
                report_mismatch("tdata padding", 0, int'(m_tdata[M_TDATA_W-1:LAP_W]));
            if (m_tlast !== want.frame_last)
                report_mismatch("frame_last", int'(want.frame_last), int'(m_tlast));
        end
        results_seen++;
    endtask

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) check_result_beat();
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset geometry: first results appear one row plus one pixel in
    task automatic test_reset_geometry();
        source_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        for (int i = 0; i < WIDTH_DEFAULT + 20; i++) push_pixel_beat(OP_PIXEL, random_pixel());
        wait_for_results();
    endtask

    // Low clamp, full-scale results and ignored drain payload
    task automatic test_directed_extremes();
        int plus_pattern[9];
        plus_pattern = '{0, 255, 0, 255, 0, 255, 0, 255, 0};
        source_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        // width 1 and height 0 both saturate to 2
        set_geometry(1, 0);
        push_pixel_beat(OP_PIXEL, 8'hFF);
        push_pixel_beat(OP_PIXEL, 8'h00);
        push_pixel_beat(OP_PIXEL, 8'h00);
        push_pixel_beat(OP_PIXEL, 8'hFF);
        for (int i = 0; i < 3; i++) push_pixel_beat(OP_DRAIN, 8'hFF);
        // 3x3 plus pattern reaches +1020 at the center and -1020 on the edges
        set_geometry(3, 3);
        foreach (plus_pattern[i]) push_pixel_beat(OP_PIXEL, PIXEL_W'(plus_pattern[i]));
        for (int i = 0; i < 4; i++) push_pixel_beat(OP_DRAIN, 8'hA5);
        // a drain inside the frame counts as a zero pixel, a pixel past it as a drain
        set_geometry(2, 2);
        push_pixel_beat(OP_PIXEL, 8'hC3);
        push_pixel_beat(OP_DRAIN, 8'hAA);
        push_pixel_beat(OP_PIXEL, 8'h3C);
        push_pixel_beat(OP_PIXEL, 8'hFF);
        for (int i = 0; i < 3; i++) push_pixel_beat(OP_PIXEL, 8'h55);
        wait_for_results();
    endtask

    // A register write mid-frame returns the stream to frame start
    task automatic test_register_restart();
        source_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        set_geometry(5, 3);
        for (int i = 0; i < 8; i++) push_pixel_beat(OP_PIXEL, random_pixel());
        write_register(REG_IMAGE_HEIGHT, 3);
        send_frame();
        for (int i = 0; i < 11; i++) push_pixel_beat(OP_PIXEL, random_pixel());
        write_register(REG_IMAGE_WIDTH, 4);
        send_frame();
        wait_for_results();
    endtask

    // Mostly well-formed small frames, some noise and cut-short frames
    task automatic test_random_frames();
        int sent, w, h, n, roll;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            source_gaps_on = ($urandom_range(0, 99) >= 15);
            sink_stalls_on = ($urandom_range(0, 99) >= 15);
            if ($urandom_range(0, 99) < 50) begin
                roll = $urandom_range(0, 99);
                if (roll < 90) w = $urandom_range(2, 12);
                else if (roll < 95) w = $urandom_range(0, 1);
                else w = $urandom_range(13, 24);
                roll = $urandom_range(0, 99);
                if (roll < 90) h = $urandom_range(2, 8);
                else if (roll < 95) h = $urandom_range(0, 1);
                else h = $urandom_range(9, 16);
                set_geometry(w, h);
            end
            w = frame_w();
            h = frame_h();
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                send_frame();
                sent += w * h + w + 1;
            end else if (roll < 90) begin
                // random mix of pixel and drain beats
                n = $urandom_range(1, 2 * w * h);
                for (int i = 0; i < n; i++)
                    push_pixel_beat($urandom_range(0, 1) == 1 ? OP_DRAIN : OP_PIXEL,
                                    random_pixel());
                sent += n;
            end else begin
                // partial frame, then hold off until the output is empty
                n = $urandom_range(1, w * h + w);
                for (int i = 0; i < n; i++)
                    push_pixel_beat(i < w * h ? OP_PIXEL : OP_DRAIN, random_pixel());
                wait_for_results();
                sent += n;
            end
        end
        wait_for_results();
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial begin
        int spins;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_PIXEL;
        source_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        mismatch_count = 0;
        results_seen   = 0;
        reset_predictor();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_geometry();
        test_directed_extremes();
        test_register_restart();
        test_random_frames();

        // let the pipeline empty, then look for leftovers
        @(negedge aclk);
        s_tvalid <= 1'b0;
        spins = 0;
        while (pending_laplacians.size() != 0 && spins < 5000) begin
            @(posedge aclk);
            spins++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_laplacians.size() != 0)
            report_mismatch("results never delivered", 0, pending_laplacians.size());

        if (mismatch_count == 0) begin
            $display("five_point_laplacian_zero_border_unit verification clean");
        end else begin
            $display("five_point_laplacian_zero_border_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/lapzb_pkg.sv
design/five_point_laplacian_zero_border_unit.sv
design/lapzb_checker.sv
bench/five_point_laplacian_zero_border_unit_test.sv
